// File: hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL of the quadratic root solver.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked every cycle outside reset.
`define QRS_ASSERT_IMP(lbl, ant, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ant) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, also checked during reset.
`define QRS_ASSERT_NXT(lbl, ant, cons, msg) \
    lbl: assert property (@(posedge i_clk) (ant) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/qrs_pkg.sv
// Types and constants of the quadratic root solver.
`timescale 1ns / 1ps
`default_nettype none

package qrs_pkg;

    typedef enum logic [1:0] {
        KIND_TWO    = 2'd0,
        KIND_DOUBLE = 2'd1,
        KIND_NONE   = 2'd2,
        KIND_A_ZERO = 2'd3
    } t_root_kind;

    localparam int OUT_FRAC = 16;
    localparam int ROOT_W   = 32;

    localparam logic [ROOT_W:0] ROOT_MAX     = 33'h0_7FFF_FFFF;
    localparam logic [ROOT_W:0] ROOT_MIN_MAG = 33'h0_8000_0000;

endpackage

`default_nettype wire

// File: hw/rtl/qrs_div_pipe.sv
// Pipelined restoring divider, one quotient bit per stage, rounding done by caller.
`timescale 1ns / 1ps
`default_nettype none

module qrs_div_pipe #(
    parameter int NUM_W = 36,
    parameter int DEN_W = 18
) (
    input  wire logic             i_clk,
    input  wire logic             i_en,
    input  wire logic [NUM_W-1:0] i_num,
    input  wire logic [DEN_W-1:0] i_den,
    input  wire logic             i_neg,
    output logic      [NUM_W-1:0] o_quo,
    output logic                  o_neg
);

    logic [NUM_W-1:0] r_num [NUM_W];
    logic [DEN_W-1:0] r_den [NUM_W];
    logic [DEN_W-1:0] r_rem [NUM_W];
    logic [NUM_W-1:0] r_quo [NUM_W];
    logic             r_neg [NUM_W];

    for (genvar k = 0; k < NUM_W; k++) begin : g_step
        logic [NUM_W-1:0] p_num;
        logic [DEN_W-1:0] p_den;
        logic [DEN_W-1:0] p_rem;
        logic [NUM_W-1:0] p_quo;
        logic             p_neg;
        logic [DEN_W:0]   rsh;
        logic             take;

        if (k == 0) begin : g_first
            assign p_num = i_num;
            assign p_den = i_den;
            assign p_rem = '0;
            assign p_quo = '0;
            assign p_neg = i_neg;
        end else begin : g_next
            assign p_num = r_num[k-1];
            assign p_den = r_den[k-1];
            assign p_rem = r_rem[k-1];
            assign p_quo = r_quo[k-1];
            assign p_neg = r_neg[k-1];
        end

        assign rsh  = {p_rem, p_num[NUM_W-1]};
        assign take = rsh >= {1'b0, p_den};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_num[k] <= p_num << 1;
                r_den[k] <= p_den;
                r_rem[k] <= take ? DEN_W'(rsh - {1'b0, p_den}) : rsh[DEN_W-1:0];
                r_quo[k] <= {p_quo[NUM_W-2:0], take};
                r_neg[k] <= p_neg;
            end
        end
    end

    assign o_quo = r_quo[NUM_W-1];
    assign o_neg = r_neg[NUM_W-1];

endmodule

`default_nettype wire

// File: hw/rtl/quadratic_root_solver_unit.sv
// Top level of the quadratic root solver: discriminant, square root and root division.
//
// Usage: present coefficients a, b, c (signed, COEF_WIDTH bits, common scale) on
// i_coef_* with i_valid; a request is taken when i_valid and o_ready are high.
// Results leave on o_root_plus, o_root_minus (Q16.16), o_root_kind and
// o_overflowed with o_valid, and are taken when o_valid and i_ready are high.
// One request is accepted every cycle while the output is not stalled. SW =
// COEF_WIDTH + SQ + 1 is the number of square-root stages (one root bit each)
// and XW is the number of divider stages (one quotient bit each). The two
// roots use two dividers side by side.
// All stages advance together: when a result waits at the output and i_ready
// is low, the whole pipeline holds and o_ready drops, nothing is lost.
// Synchronous reset empties the pipeline; o_valid is low the cycle after.
// A zero a, or a negative discriminant, gives zero roots and no overflow flag.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module quadratic_root_solver_unit #(
    parameter int COEF_WIDTH = 16
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_valid,
    output logic                                o_ready,
    input  wire logic signed [COEF_WIDTH-1:0]   i_coef_a,
    input  wire logic signed [COEF_WIDTH-1:0]   i_coef_b,
    input  wire logic signed [COEF_WIDTH-1:0]   i_coef_c,
    output logic                                o_valid,
    input  wire logic                           i_ready,
    output logic signed [qrs_pkg::ROOT_W-1:0]   o_root_plus,
    output logic signed [qrs_pkg::ROOT_W-1:0]   o_root_minus,
    output logic        [1:0]                   o_root_kind,
    output logic                                o_overflowed
);

    localparam int W   = COEF_WIDTH;
    localparam int RTW = qrs_pkg::ROOT_W;
    localparam int SQ  = (2 * W < 63) ? (63 - 2 * W) / 2 : 0;
    localparam int OF  = qrs_pkg::OUT_FRAC;
    localparam int NSH = (SQ <= OF) ? OF - SQ : 0;
    localparam int DSH = (SQ > OF) ? SQ - OF : 0;
    localparam int DW  = 2 * W + 2;
    localparam int SW  = W + SQ + 1;
    localparam int RW  = 2 * SW;
    localparam int RMW = SW + 2;
    localparam int MW  = SW + 1;
    localparam int NW  = SW + 2;
    localparam int AW  = W + 1 + DSH;
    localparam int XW  = ((MW + NSH + 1 > AW) ? MW + NSH + 1 : AW) + 1;
    localparam int YW  = AW + 1;
    localparam int L   = 5 + SW + XW;

    logic en;
    logic r_vld [L];

    assign en      = !r_vld[L-1] || i_ready;
    assign o_ready = en;
    assign o_valid = r_vld[L-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < L; i++) r_vld[i] <= 1'b0;
        end else if (en) begin
            r_vld[0] <= i_valid;
            for (int i = 1; i < L; i++) r_vld[i] <= r_vld[i-1];
        end
    end

    // input, products, discriminant
    logic signed [W-1:0]   r0_a, r0_b, r0_c;
    logic signed [2*W-1:0] r1_bb, r1_ac;
    logic signed [W-1:0]   r1_a, r1_b;
    logic signed [W-1:0]   r2_a, r2_b;
    logic [RW-1:0]         r2_rad;
    qrs_pkg::t_root_kind   r2_kind;
    logic signed [DW-1:0]  disc;
    qrs_pkg::t_root_kind   n2_kind;

    always_comb begin
        disc = DW'(r1_bb) - (DW'(r1_ac) <<< 2);
        if (r1_a == '0) begin
            n2_kind = qrs_pkg::KIND_A_ZERO;
        end else if (disc[DW-1]) begin
            n2_kind = qrs_pkg::KIND_NONE;
        end else if (disc == '0) begin
            n2_kind = qrs_pkg::KIND_DOUBLE;
        end else begin
            n2_kind = qrs_pkg::KIND_TWO;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r0_a    <= i_coef_a;
            r0_b    <= i_coef_b;
            r0_c    <= i_coef_c;
            r1_bb   <= (2*W)'(r0_b) * (2*W)'(r0_b);
            r1_ac   <= (2*W)'(r0_a) * (2*W)'(r0_c);
            r1_a    <= r0_a;
            r1_b    <= r0_b;
            r2_a    <= r1_a;
            r2_b    <= r1_b;
            r2_kind <= n2_kind;
            r2_rad  <= disc[DW-1] ? '0 : (RW'($unsigned(disc)) << (2 * SQ));
        end
    end

    // square root, two radicand bits per stage
    logic [RW-1:0]       r_sq_rad  [SW];
    logic [RMW-1:0]      r_sq_rem  [SW];
    logic [SW-1:0]       r_sq_root [SW];
    logic signed [W-1:0] r_sq_a    [SW];
    logic signed [W-1:0] r_sq_b    [SW];
    qrs_pkg::t_root_kind r_sq_kind [SW];

    for (genvar k = 0; k < SW; k++) begin : g_sqrt
        logic [RW-1:0]       p_rad;
        logic [RMW-1:0]      p_rem;
        logic [SW-1:0]       p_root;
        logic signed [W-1:0] p_a, p_b;
        qrs_pkg::t_root_kind p_kind;
        logic [RMW-1:0]      rsh, trial;
        logic                take;

        if (k == 0) begin : g_first
            assign p_rad  = r2_rad;
            assign p_rem  = '0;
            assign p_root = '0;
            assign p_a    = r2_a;
            assign p_b    = r2_b;
            assign p_kind = r2_kind;
        end else begin : g_next
            assign p_rad  = r_sq_rad[k-1];
            assign p_rem  = r_sq_rem[k-1];
            assign p_root = r_sq_root[k-1];
            assign p_a    = r_sq_a[k-1];
            assign p_b    = r_sq_b[k-1];
            assign p_kind = r_sq_kind[k-1];
        end

        assign rsh   = {p_rem[RMW-3:0], p_rad[RW-1:RW-2]};
        assign trial = {p_root, 2'b01};
        assign take  = rsh >= trial;

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_sq_rad[k]  <= p_rad << 2;
                r_sq_rem[k]  <= take ? RMW'(rsh - trial) : rsh;
                r_sq_root[k] <= {p_root[SW-2:0], take};
                r_sq_a[k]    <= p_a;
                r_sq_b[k]    <= p_b;
                r_sq_kind[k] <= p_kind;
            end
        end
    end

    // numerators and divisor
    logic signed [NW-1:0] nb, sx, np, nm;
    logic signed [W:0]    a_ext;
    logic [W:0]           amag;
    logic [AW-1:0]        dmv;
    logic [MW-1:0]        mag_p, mag_m;
    logic [XW-1:0]        r3_num_p, r3_num_m;
    logic [YW-1:0]        r3_den;
    logic                 r3_neg_p, r3_neg_m;
    qrs_pkg::t_root_kind  r3_kind;

    always_comb begin
        nb    = -(NW'(r_sq_b[SW-1])) <<< SQ;
        sx    = $signed(NW'(r_sq_root[SW-1]));
        np    = nb + sx;
        nm    = nb - sx;
        mag_p = np[NW-1] ? MW'(-np) : MW'(np);
        mag_m = nm[NW-1] ? MW'(-nm) : MW'(nm);
        a_ext = (W+1)'(r_sq_a[SW-1]);
        amag  = a_ext[W] ? $unsigned(-a_ext) : $unsigned(a_ext);
        dmv   = AW'(amag) << (1 + DSH);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_num_p <= (XW'(mag_p) << (NSH + 1)) + XW'(dmv);
            r3_num_m <= (XW'(mag_m) << (NSH + 1)) + XW'(dmv);
            r3_den   <= YW'(dmv) << 1;
            r3_neg_p <= np[NW-1] ^ r_sq_a[SW-1][W-1];
            r3_neg_m <= nm[NW-1] ^ r_sq_a[SW-1][W-1];
            r3_kind  <= r_sq_kind[SW-1];
        end
    end

    // dividers
    logic [XW-1:0]       quo_p, quo_m;
    logic                neg_p, neg_m;
    qrs_pkg::t_root_kind r_dv_kind [XW];

    qrs_div_pipe #(.NUM_W(XW), .DEN_W(YW)) u_div_plus (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (r3_num_p),
        .i_den (r3_den),
        .i_neg (r3_neg_p),
        .o_quo (quo_p),
        .o_neg (neg_p)
    );

    qrs_div_pipe #(.NUM_W(XW), .DEN_W(YW)) u_div_minus (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (r3_num_m),
        .i_den (r3_den),
        .i_neg (r3_neg_m),
        .o_quo (quo_m),
        .o_neg (neg_m)
    );

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dv_kind[0] <= r3_kind;
            for (int i = 1; i < XW; i++) r_dv_kind[i] <= r_dv_kind[i-1];
        end
    end

    // saturation and sign
    function automatic logic [RTW:0] f_sat(input logic [XW-1:0] q, input logic neg);
        logic [XW-1:0]  lim;
        logic           sat;
        logic [RTW-1:0] mag;
        lim = neg ? XW'(qrs_pkg::ROOT_MIN_MAG) : XW'(qrs_pkg::ROOT_MAX);
        sat = q > lim;
        mag = sat ? lim[RTW-1:0] : q[RTW-1:0];
        return {sat, neg ? -mag : mag};
    endfunction

    logic [RTW:0]        fp, fm;
    logic                real_roots;
    qrs_pkg::t_root_kind dv_kind;
    logic [RTW-1:0]      r_out_plus, r_out_minus;
    qrs_pkg::t_root_kind r_out_kind;
    logic                r_out_ovf;

    always_comb begin
        dv_kind    = r_dv_kind[XW-1];
        fp         = f_sat(quo_p, neg_p);
        fm         = f_sat(quo_m, neg_m);
        real_roots = (dv_kind == qrs_pkg::KIND_TWO) || (dv_kind == qrs_pkg::KIND_DOUBLE);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_plus  <= real_roots ? fp[RTW-1:0] : '0;
            r_out_minus <= real_roots ? fm[RTW-1:0] : '0;
            r_out_ovf   <= real_roots && (fp[RTW] || fm[RTW]);
            r_out_kind  <= dv_kind;
        end
    end

    assign o_root_plus  = $signed(r_out_plus);
    assign o_root_minus = $signed(r_out_minus);
    assign o_root_kind  = r_out_kind;
    assign o_overflowed = r_out_ovf;

    `QRS_ASSERT_NXT(a_rst_empty, !i_rst_n, !o_valid, "valid out of reset")
    `QRS_ASSERT_IMP(a_no_roots_zero,
        o_valid && (o_root_kind == qrs_pkg::KIND_NONE || o_root_kind == qrs_pkg::KIND_A_ZERO),
        o_root_plus == '0 && o_root_minus == '0 && !o_overflowed, "roots without real roots")
    `QRS_ASSERT_IMP(a_double_equal, o_valid && o_root_kind == qrs_pkg::KIND_DOUBLE,
        o_root_plus == o_root_minus, "double root differs")
    `QRS_ASSERT_IMP(a_hold_on_stall, o_valid && !i_ready, !o_ready, "took request while stalled")

endmodule

`default_nettype wire
